// ===== hdl/bfp_pkg.sv =====
// Shared constants, codes, types and helper functions of the best-fit buffer pool.
package bfp_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int BYTES_W = 32;
  localparam int CMD_W   = 2;
  localparam int OUTC_W  = 2;
  localparam int FCNT_W  = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // Release outcomes.
  localparam logic [OUTC_W-1:0] OUTC_NONE    = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_ACCEPT  = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_DISCARD = 2'd2;
  localparam logic [OUTC_W-1:0] OUTC_ZERO    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUF_CAP          = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SINGLE_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAP        = 2'd2;

  localparam logic [FCNT_W-1:0]  BUF_CAP_RST   = 5'd4;
  localparam logic [BYTES_W-1:0] MAX_BYTES_RST = '1;

  typedef struct packed {
    logic               clear;
    logic               remove;
    logic [IDX_W-1:0]   remove_idx;
    logic               insert;
    logic [BYTES_W-1:0] insert_bytes;
  } tbl_ctrl_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic               found;
    logic [IDX_W-1:0]   best_idx;
    logic [BYTES_W-1:0] best_bytes;
  } scan_stat_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [FCNT_W-1:0] sat_field(input logic [CNT_W-1:0] v);
    sat_field = (32'(v) > 32'd31) ? 5'd31 : FCNT_W'(v);
  endfunction

endpackage

// ===== hdl/bfp_ifs.sv =====
// Channel interfaces of the best-fit buffer pool: request, result and configuration.
interface bfp_req_if;
  import bfp_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [BYTES_W-1:0] byte_count;
  modport source(output valid, command, byte_count, input ready);
  modport sink(input valid, command, byte_count, output ready);
endinterface

interface bfp_rsp_if;
  import bfp_pkg::*;
  logic               valid;
  logic               ready;
  logic               hit;
  logic [BYTES_W-1:0] granted_bytes;
  logic [OUTC_W-1:0]  release_outcome;
  logic [FCNT_W-1:0]  evicted_now;
  logic [FCNT_W-1:0]  retained_count;
  logic [BYTES_W-1:0] retained_total;
  logic [31:0]        acquire_total;
  logic [31:0]        hit_total;
  logic [31:0]        evict_total;
  logic [31:0]        accept_total;
  logic [31:0]        discard_total;
  modport source(output valid, hit, granted_bytes, release_outcome, evicted_now,
                 retained_count, retained_total, acquire_total, hit_total,
                 evict_total, accept_total, discard_total, input ready);
  modport sink(input valid, hit, granted_bytes, release_outcome, evicted_now,
               retained_count, retained_total, acquire_total, hit_total,
               evict_total, accept_total, discard_total, output ready);
endinterface

interface bfp_cfg_if;
  import bfp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/bfp_table.sv =====
// Slot table: valid bits, stored sizes, occupancy count and free-slot pick.
module bfp_table (
  input  logic                    clk,
  input  logic                    rst,
  input  bfp_pkg::tbl_ctrl_t      ctrl,
  input  logic [bfp_pkg::IDX_W-1:0] rd_idx,
  output logic                    rd_valid,
  output logic [bfp_pkg::BYTES_W-1:0] rd_bytes,
  output logic [bfp_pkg::CNT_W-1:0] held
);
  import bfp_pkg::*;

  logic [SLOTS-1:0]   slot_valid;
  logic [BYTES_W-1:0] slot_bytes [SLOTS];
  logic [IDX_W-1:0]   free_idx;

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = IDX_W'(i);
    end
  end

  assign rd_valid = slot_valid[rd_idx];
  assign rd_bytes = slot_bytes[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      held       <= '0;
    end else if (ctrl.clear) begin
      slot_valid <= '0;
      held       <= '0;
    end else if (ctrl.remove) begin
      slot_valid[ctrl.remove_idx] <= 1'b0;
      held <= held - CNT_W'(1);
    end else if (ctrl.insert) begin
      slot_valid[free_idx] <= 1'b1;
      held <= held + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && !ctrl.clear && !ctrl.remove) begin
      slot_bytes[free_idx] <= ctrl.insert_bytes;
    end
  end

  a_held_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(held) == 32'($countones(slot_valid)))
    else $error("occupancy count disagrees with valid bits");

endmodule

// ===== hdl/bfp_scan.sv =====
// Shared compare unit: walks the slots one per cycle for the smallest size at or above a floor.
module bfp_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [bfp_pkg::BYTES_W-1:0] floor_bytes,
  output logic [bfp_pkg::IDX_W-1:0]   rd_idx,
  input  logic                        ent_valid,
  input  logic [bfp_pkg::BYTES_W-1:0] ent_bytes,
  output bfp_pkg::scan_stat_t         stat
);
  import bfp_pkg::*;

  logic               busy;
  logic               done;
  logic               found;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   best_idx;
  logic [BYTES_W-1:0] best_bytes;
  logic [BYTES_W-1:0] floor_q;
  logic               cand;
  logic               last;

  // Strict less-than keeps the lowest index on equal sizes.
  assign cand = ent_valid && (ent_bytes >= floor_q) && (!found || ent_bytes < best_bytes);
  assign last = (idx == IDX_W'(SLOTS - 1));
  assign rd_idx = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx     <= '0;
      found   <= 1'b0;
      floor_q <= floor_bytes;
    end else if (busy) begin
      if (cand) begin
        found      <= 1'b1;
        best_idx   <= idx;
        best_bytes <= ent_bytes;
      end
      if (!last) idx <= idx + IDX_W'(1);
    end
  end

  assign stat.busy       = busy;
  assign stat.done       = done;
  assign stat.found      = found;
  assign stat.best_idx   = best_idx;
  assign stat.best_bytes = best_bytes;

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("scan restarted while busy");

  a_found_fits: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (best_bytes >= floor_q))
    else $error("scan result below floor");

endmodule

// ===== hdl/best_fit_buffer_pool.sv =====
// Top level of the best-fit buffer pool: sequencer, budgets, counters and result register.
// Acquire: one 16-slot scan from acceptance to a valid result. A clear, or a zero-size or
// oversize release, goes straight to the result. Any other release: a budget check, then
// per eviction a smallest-entry scan and a new check, then the final budget decision.
// Throughput: one transaction at a time; the scan unit reads one slot per cycle.
// Reset (rst, synchronous): table empty, counters zero, budgets at their reset values.
module best_fit_buffer_pool (
  input  logic        clk,
  input  logic        rst,
  bfp_req_if.sink     req,
  bfp_rsp_if.source   rsp,
  bfp_cfg_if.sink     cfg
);
  import bfp_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN_ACQ = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_SCAN_EV  = 3'd3;
  localparam logic [2:0] S_FINAL    = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0] state;

  // Budgets.
  logic [FCNT_W-1:0]  buf_cap;
  logic [BYTES_W-1:0] max_single_bytes;
  logic [BYTES_W-1:0] total_cap;

  // Item being worked on.
  logic [CMD_W-1:0]   cmd;
  logic [BYTES_W-1:0] size;

  // Result fields.
  logic               res_hit;
  logic [BYTES_W-1:0] res_granted;
  logic [OUTC_W-1:0]  res_outcome;
  logic [CNT_W-1:0]   evict_run;

  // Telemetry.
  logic [BYTES_W-1:0] held_sum;
  logic [31:0]        acquire_count;
  logic [31:0]        hit_count;
  logic [31:0]        evict_count;
  logic [31:0]        accept_count;
  logic [31:0]        discard_count;

  tbl_ctrl_t          tctl;
  scan_stat_t         sstat;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_valid;
  logic [BYTES_W-1:0] rd_bytes;
  logic [CNT_W-1:0]   held;
  logic               scan_start;
  logic [BYTES_W-1:0] scan_floor;
  logic [CNT_W-1:0]   cnt_limit;
  logic               fits;
  logic               accept_in;

  assign accept_in = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  // Count budget above the table size acts as the table size.
  assign cnt_limit = (32'(buf_cap) > 32'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(buf_cap);

  // Both budgets must allow one more entry of the current size.
  assign fits = (held < cnt_limit) && (held_sum <= total_cap) &&
                (size <= total_cap - held_sum);

  // Start a scan: best fit for an acquire, smallest entry for an eviction.
  assign scan_start = (state == S_IDLE && accept_in && req.command == CMD_ACQUIRE) ||
                      (state == S_CHECK && held != '0 && !fits);
  assign scan_floor = (state == S_IDLE) ? req.byte_count : '0;

  // Table writes: clear on a clear command, remove on a hit or an eviction,
  // insert when a release survives the budget check.
  always_comb begin
    tctl = '0;
    tctl.remove_idx   = sstat.best_idx;
    tctl.insert_bytes = size;
    case (state)
      S_IDLE: begin
        tctl.clear = accept_in && (req.command == CMD_CLEAR);
      end
      S_SCAN_ACQ: begin
        tctl.remove = sstat.done && sstat.found;
      end
      S_SCAN_EV: begin
        tctl.remove = sstat.done && sstat.found && (sstat.best_bytes < size);
      end
      S_FINAL: begin
        tctl.insert = fits;
      end
      default: begin
        tctl = tctl;
      end
    endcase
  end

  bfp_table u_table (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (tctl),
    .rd_idx   (rd_idx),
    .rd_valid (rd_valid),
    .rd_bytes (rd_bytes),
    .held     (held)
  );

  bfp_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .start       (scan_start),
    .floor_bytes (scan_floor),
    .rd_idx      (rd_idx),
    .ent_valid   (rd_valid),
    .ent_bytes   (rd_bytes),
    .stat        (sstat)
  );

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cap          <= BUF_CAP_RST;
      max_single_bytes <= MAX_BYTES_RST;
      total_cap        <= MAX_BYTES_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_BUF_CAP:          buf_cap          <= cfg.data[FCNT_W-1:0];
        REG_MAX_SINGLE_BYTES: max_single_bytes <= cfg.data[BYTES_W-1:0];
        REG_TOTAL_CAP:        total_cap        <= cfg.data[BYTES_W-1:0];
        default:              buf_cap          <= buf_cap;
      endcase
    end
  end

  // Sequencer, counters and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      held_sum      <= '0;
      acquire_count <= '0;
      hit_count     <= '0;
      evict_count   <= '0;
      accept_count  <= '0;
      discard_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept_in) begin
            case (req.command)
              CMD_ACQUIRE: begin
                acquire_count <= sat_inc(acquire_count);
                state <= S_SCAN_ACQ;
              end
              CMD_RELEASE: begin
                if (req.byte_count == '0) begin
                  state <= S_OUT;
                end else if (req.byte_count > max_single_bytes ||
                             req.byte_count > total_cap) begin
                  discard_count <= sat_inc(discard_count);
                  state <= S_OUT;
                end else begin
                  state <= S_CHECK;
                end
              end
              CMD_CLEAR: begin
                held_sum      <= '0;
                acquire_count <= '0;
                hit_count     <= '0;
                evict_count   <= '0;
                accept_count  <= '0;
                discard_count <= '0;
                state <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN_ACQ: begin
          if (sstat.done) begin
            if (sstat.found) begin
              hit_count <= sat_inc(hit_count);
              held_sum  <= held_sum - sstat.best_bytes;
            end
            state <= S_OUT;
          end
        end
        S_CHECK: begin
          // Evict only while something is held and a budget is exceeded.
          state <= (held != '0 && !fits) ? S_SCAN_EV : S_FINAL;
        end
        S_SCAN_EV: begin
          if (sstat.done) begin
            if (sstat.found && sstat.best_bytes < size) begin
              held_sum    <= held_sum - sstat.best_bytes;
              evict_count <= sat_inc(evict_count);
              state <= S_CHECK;
            end else begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (fits) begin
            held_sum     <= held_sum + size;
            accept_count <= sat_inc(accept_count);
          end else begin
            discard_count <= sat_inc(discard_count);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (rsp.ready) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload; hold while the result waits.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept_in) begin
          cmd         <= req.command;
          size        <= req.byte_count;
          res_hit     <= 1'b0;
          res_granted <= '0;
          evict_run   <= '0;
          res_outcome <= OUTC_NONE;
          if (req.command == CMD_RELEASE) begin
            if (req.byte_count == '0) begin
              res_outcome <= OUTC_ZERO;
            end else if (req.byte_count > max_single_bytes ||
                         req.byte_count > total_cap) begin
              res_outcome <= OUTC_DISCARD;
            end
          end
        end
      end
      S_SCAN_ACQ: begin
        if (sstat.done && sstat.found) begin
          res_hit     <= 1'b1;
          res_granted <= sstat.best_bytes;
        end
      end
      S_SCAN_EV: begin
        if (sstat.done && sstat.found && sstat.best_bytes < size) begin
          evict_run <= evict_run + CNT_W'(1);
        end
      end
      S_FINAL: begin
        res_outcome <= fits ? OUTC_ACCEPT : OUTC_DISCARD;
      end
      default: begin
        res_hit <= res_hit;
      end
    endcase
  end

  assign rsp.valid           = (state == S_OUT);
  assign rsp.hit             = res_hit;
  assign rsp.granted_bytes   = res_granted;
  assign rsp.release_outcome = res_outcome;
  assign rsp.evicted_now     = sat_field(evict_run);
  assign rsp.retained_count  = sat_field(held);
  assign rsp.retained_total  = held_sum;
  assign rsp.acquire_total   = acquire_count;
  assign rsp.hit_total       = hit_count;
  assign rsp.evict_total     = evict_count;
  assign rsp.accept_total    = accept_count;
  assign rsp.discard_total   = discard_count;

  a_empty_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (held == '0) |-> (held_sum == '0))
    else $error("byte sum nonzero with an empty table");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (rst)
    (accept_in && req.command == CMD_CLEAR) |=>
      (held_sum == '0 && acquire_count == '0 && held == '0))
    else $error("clear left telemetry behind");

  a_hit_fits: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && res_hit) |-> (cmd == CMD_ACQUIRE && res_granted >= size))
    else $error("granted entry smaller than request");

  a_hit_not_release: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(res_hit && res_outcome != OUTC_NONE))
    else $error("hit reported on a release");

endmodule
